/* rtl/sat_pkg.sv */
// sat_pkg: shared types and constants of the separating-axis collision block
// no dependencies
`default_nettype none
package sat_pkg;
   localparam int OVL_LIMIT = 65535;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_AXIS,
      ST_PROJ,
      ST_CHECK,
      ST_EXT,
      ST_SWAP,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // store the incoming vertex
      logic start;       // begin the test
      logic axis_load;   // form axis from current edge
      logic proj_step;   // project one vertex of each polygon
      logic proj_init;   // start new intervals
      logic ext_load;    // latch the next extent axis
      logic finish;      // register result and clear counts
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bad;
      logic proj_last;   // last projection step this cycle
      logic edge_last;   // axis in use came from the last edge of all
      logic gap;         // intervals are apart
      logic ext_last;    // second extent axis in use
   } sts_type;
endpackage
`default_nettype wire

/* rtl/sat_polygon_collision_top.sv */
// sat_polygon_collision_top: separating-axis test of two convex polygons
// One vertex is taken per cycle while the block is loading. After the last vertex of polygon B the test
// runs every edge axis of A then B, each through the shared projection unit (two dot products per
// cycle) and then a compare state, then the two extent axes x and y with a switch state between.
// A gap on any edge axis stops the walk early. Depends on sat_pkg, sat_ctrl and
// sat_datapath.
`default_nettype none
module sat_polygon_collision_top
   import sat_pkg::*;
#(
   parameter int MaxVertices = 8,
   parameter int CoordWidth  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // vertex_x[15:0], vertex_y[31:16]
   input  wire logic        req_tuser,  // func
   input  wire logic        req_tlast,  // last_vertex
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // collided, overlap_x, overlap_y, bad_input, pad
   output logic             rsp_tlast
);
   cmd_type cmd;
   sts_type sts;
   logic hit, bad;
   logic [16:0] ox, oy;
   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   sat_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_b(req_tuser), .req_last(req_tlast),
      .sts, .rsp_fire(rsp_tvalid && rsp_tready), .cmd,
      .req_ready(req_tready), .rsp_valid(rsp_tvalid)
   );

   sat_datapath #(.MaxVertices(MaxVertices), .CoordWidth(CoordWidth)) u_dp (
      .clock, .reset, .cmd, .in_b(req_tuser), .in_x(req_tdata[15:0]),
      .in_y(req_tdata[31:16]), .in_last(req_tlast), .sts,
      .res_hit(hit), .res_ox(ox), .res_oy(oy), .res_bad(bad)
   );

   assign rsp_tdata = {4'b0, bad, oy, ox, hit};
   assign rsp_tlast = 1'b1;
endmodule
`default_nettype wire

/* rtl/sat_datapath.sv */
// sat_datapath: vertex stores, projection unit and result registers
// depends on sat_pkg
`default_nettype none
module sat_datapath
   import sat_pkg::*;
#(
   parameter int MaxVertices = 8,
   parameter int CoordWidth  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic        in_b,
   input  wire logic [15:0] in_x,
   input  wire logic [15:0] in_y,
   input  wire logic        in_last,
   output sts_type          sts,
   output logic            res_hit,
   output logic [16:0]     res_ox,
   output logic [16:0]     res_oy,
   output logic            res_bad
);
   localparam int IW = $clog2(MaxVertices);
   localparam int CW = $clog2(MaxVertices + 1);
   localparam int DW = CoordWidth + 1;
   localparam int PW = 2 * DW + 2;

   logic signed [CoordWidth-1:0] ax_ff [MaxVertices];
   logic signed [CoordWidth-1:0] ay_ff [MaxVertices];
   logic signed [CoordWidth-1:0] bx_ff [MaxVertices];
   logic signed [CoordWidth-1:0] by_ff [MaxVertices];
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic ovf_ff, ovf_in, a_closed_ff, a_closed_in;

   logic signed [CoordWidth-1:0] sx, sy;
   assign sx = in_x[CoordWidth-1:0];
   assign sy = in_y[CoordWidth-1:0];

   // vertex stores
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (!in_b && !(a_closed_ff ? 1'b0 : (cnt_a_ff == CW'(MaxVertices)))) begin
            ax_ff[a_closed_ff ? IW'(0) : cnt_a_ff[IW-1:0]] <= sx;
            ay_ff[a_closed_ff ? IW'(0) : cnt_a_ff[IW-1:0]] <= sy;
         end
         if (in_b && cnt_b_ff != CW'(MaxVertices)) begin
            bx_ff[cnt_b_ff[IW-1:0]] <= sx;
            by_ff[cnt_b_ff[IW-1:0]] <= sy;
         end
      end
   end

   // counts and flags
   always_comb begin
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      ovf_in      = ovf_ff;
      a_closed_in = a_closed_ff;
      if (cmd.load) begin
         if (!in_b) begin
            if (a_closed_ff) cnt_a_in = '0;
            if (cnt_a_in == CW'(MaxVertices)) ovf_in = 1'b1;
            else cnt_a_in = cnt_a_in + CW'(1);
            a_closed_in = in_last;
         end else begin
            if (cnt_b_ff == CW'(MaxVertices)) ovf_in = 1'b1;
            else cnt_b_in = cnt_b_ff + CW'(1);
         end
      end
      if (cmd.finish) begin
         cnt_a_in = '0; cnt_b_in = '0; ovf_in = 1'b0; a_closed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0; cnt_b_ff <= '0; ovf_ff <= 1'b0; a_closed_ff <= 1'b0;
      end else begin
         cnt_a_ff <= cnt_a_in; cnt_b_ff <= cnt_b_in;
         ovf_ff <= ovf_in; a_closed_ff <= a_closed_in;
      end
   end

   assign sts.bad = ovf_ff || cnt_a_ff == '0 || cnt_b_ff == '0;

   // edge walk: edge index over A then B, back at zero between tests
   logic [IW:0] edge_ff, edge_in;
   logic        edge_done_ff;
   logic        on_b;
   logic [IW-1:0] ei, ej;
   logic [CW-1:0] ne;
   assign on_b = edge_ff[IW];
   assign ei   = edge_ff[IW-1:0];
   assign ne   = on_b ? cnt_b_ff : cnt_a_ff;
   assign ej   = ({1'b0, ei} + CW'(1) == ne) ? '0 : ei + IW'(1);
   assign sts.edge_last = edge_done_ff;

   always_comb begin
      edge_in = edge_ff;
      if (cmd.finish) edge_in = '0;
      else if (cmd.axis_load) begin
         if (!on_b && ({1'b0, ei} + CW'(1) == cnt_a_ff)) edge_in = {1'b1, {IW{1'b0}}};
         else edge_in = edge_ff + (IW+1)'(1);
      end
   end

   // axis register
   logic signed [DW-1:0] axx_ff, axx_in, axy_ff, axy_in;
   logic signed [DW-1:0] dx, dy;
   logic ext_x_ff, ext_y_ff;
   always_comb begin
      if (on_b) begin
         dx = DW'(bx_ff[ei]) - DW'(bx_ff[ej]);
         dy = DW'(by_ff[ei]) - DW'(by_ff[ej]);
      end else begin
         dx = DW'(ax_ff[ei]) - DW'(ax_ff[ej]);
         dy = DW'(ay_ff[ei]) - DW'(ay_ff[ej]);
      end
      axx_in = -dy;
      axy_in = dx;
      if (cmd.ext_load) begin
         axx_in = ext_x_ff ? DW'(0) : DW'(1);
         axy_in = ext_x_ff ? DW'(1) : DW'(0);
      end
   end

   // projection: one vertex of A and of B per cycle
   logic [IW-1:0] pi_ff;
   logic signed [PW-1:0] pa, pb;
   logic signed [PW-1:0] amin_ff, amax_ff, bmin_ff, bmax_ff;
   logic signed [CoordWidth-1:0] ua_x, ua_y, ub_x, ub_y;
   assign ua_x = ax_ff[pi_ff < cnt_a_ff[IW-1:0] || cnt_a_ff == CW'(MaxVertices)
                        ? pi_ff : IW'(0)];
   assign ua_y = ay_ff[pi_ff < cnt_a_ff[IW-1:0] || cnt_a_ff == CW'(MaxVertices)
                        ? pi_ff : IW'(0)];
   assign ub_x = bx_ff[pi_ff < cnt_b_ff[IW-1:0] || cnt_b_ff == CW'(MaxVertices)
                        ? pi_ff : IW'(0)];
   assign ub_y = by_ff[pi_ff < cnt_b_ff[IW-1:0] || cnt_b_ff == CW'(MaxVertices)
                        ? pi_ff : IW'(0)];
   assign pa = PW'(axx_ff) * PW'(ua_x) + PW'(axy_ff) * PW'(ua_y);
   assign pb = PW'(axx_ff) * PW'(ub_x) + PW'(axy_ff) * PW'(ub_y);
   assign sts.proj_last = ({1'b0, pi_ff} + CW'(1) >= cnt_a_ff)
                       && ({1'b0, pi_ff} + CW'(1) >= cnt_b_ff);
   assign sts.gap = amax_ff < bmin_ff || bmax_ff < amin_ff;
   assign sts.ext_last = ext_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.axis_load || cmd.ext_load) begin
         axx_ff <= axx_in; axy_ff <= axy_in;
      end
      if (cmd.proj_init) pi_ff <= '0;
      else if (cmd.proj_step) pi_ff <= pi_ff + IW'(1);
      if (cmd.proj_step) begin
         if (pi_ff == '0 || pa < amin_ff) amin_ff <= pa;
         if (pi_ff == '0 || pa > amax_ff) amax_ff <= pa;
         if (pi_ff == '0 || pb < bmin_ff) bmin_ff <= pb;
         if (pi_ff == '0 || pb > bmax_ff) bmax_ff <= pb;
      end
   end

   // walk position and extent phase
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= '0; edge_done_ff <= 1'b0; ext_x_ff <= 1'b0; ext_y_ff <= 1'b0;
      end else begin
         edge_ff <= edge_in;
         if (cmd.axis_load)
            edge_done_ff <= on_b && ({1'b0, ei} + CW'(1) == cnt_b_ff);
         if (cmd.start) begin
            ext_x_ff <= 1'b0; ext_y_ff <= 1'b0;
         end else if (cmd.ext_load) begin
            if (ext_x_ff) ext_y_ff <= 1'b1;
            else ext_x_ff <= 1'b1;
         end
      end
   end

   // extent overlap with saturation
   logic signed [PW-1:0] ovl, ovl_sat;
   assign ovl = (amin_ff <= bmin_ff) ? amax_ff - bmin_ff : bmax_ff - amin_ff;
   always_comb begin
      ovl_sat = ovl;
      if (ovl > PW'(OVL_LIMIT)) ovl_sat = PW'(OVL_LIMIT);
      if (ovl < -PW'(OVL_LIMIT)) ovl_sat = -PW'(OVL_LIMIT);
   end

   // x overlap kept aside; result registers change only when a result is launched
   logic [16:0] ox_cap_ff, ox_ff, oy_ff;
   logic        hit_ff;
   logic        res_ok;
   assign res_ok = ext_y_ff && !sts.bad;
   always_ff @(posedge clock) begin
      if (cmd.ext_load && ext_x_ff) ox_cap_ff <= ovl_sat[16:0];
      if (cmd.finish) begin
         hit_ff  <= res_ok;
         ox_ff   <= res_ok ? ox_cap_ff : '0;
         oy_ff   <= res_ok ? ovl_sat[16:0] : '0;
         res_bad <= sts.bad;
      end
   end
   assign res_hit = hit_ff;
   assign res_ox  = ox_ff;
   assign res_oy  = oy_ff;
endmodule
`default_nettype wire

/* rtl/sat_ctrl.sv */
// sat_ctrl: controller state machine and output handshake
// depends on sat_pkg
`default_nettype none
module sat_ctrl
   import sat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_fire,
   input  wire logic    req_b,
   input  wire logic    req_last,
   input  wire sts_type sts,
   input  wire logic    rsp_fire,
   output cmd_type      cmd,
   output logic         req_ready,
   output logic         rsp_valid
);
   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_fire;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               if (req_b && req_last) state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            cmd.start = 1'b1;
            if (sts.bad) state_in = ST_DONE;
            else begin
               cmd.axis_load = 1'b1;
               cmd.proj_init = 1'b1;
               state_in = ST_PROJ;
            end
         end
         ST_PROJ: begin
            cmd.proj_step = 1'b1;
            if (sts.proj_last) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.gap) state_in = ST_DONE;
            else if (sts.edge_last) begin
               cmd.ext_load = 1'b1; cmd.proj_init = 1'b1; state_in = ST_EXT;
            end else begin
               cmd.axis_load = 1'b1; cmd.proj_init = 1'b1; state_in = ST_PROJ;
            end
         end
         ST_EXT: begin
            cmd.proj_step = 1'b1;
            if (sts.proj_last) begin
               if (sts.ext_last) state_in = ST_DONE;
               else state_in = ST_SWAP;
            end
         end
         // x extents complete: keep the overlap, switch to the y axis
         ST_SWAP: begin
            cmd.ext_load = 1'b1; cmd.proj_init = 1'b1; state_in = ST_EXT;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_fire) begin
               cmd.finish = 1'b1; valid_in = 1'b1; state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in;
      end
   end
   assign rsp_valid = valid_ff;

   // a result is only launched from the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result launched outside done state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_LOAD)
      else $error("vertex stored outside load state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !valid_ff || rsp_fire)
      else $error("result overwritten while pending");
endmodule
`default_nettype wire

/* dv/tb.sv */
// tb: self-checking bench for sat_polygon_collision_top, a separating-axis test of two polygons
// drives vertex transactions with bursts and gaps, stalls the result side, checks each result
// depends on sat_pkg and sat_polygon_collision_top
`timescale 1ns / 1ps

class sat_scoreboard;
   typedef struct {
      logic        hit;
      logic [16:0] ovl_x;
      logic [16:0] ovl_y;
      logic        bad;
   } verdict_t;

   typedef struct {
      longint x;
      longint y;
   } point_t;

   point_t    poly_a[8];
   point_t    poly_b[8];
   int        n_a;
   int        n_b;
   bit        overflow;
   bit        a_done;
   verdict_t  pending[$];
   int        errors;

   function new();
      n_a = 0;
      n_b = 0;
      overflow = 0;
      a_done = 0;
      errors = 0;
   endfunction

   // dot-product interval of one polygon on an axis
   function void span(bit use_b, longint ax, longint ay, output longint lo, output longint hi);
      longint d;
      int     n;
      n = use_b ? n_b : n_a;
      for (int i = 0; i < n; i++) begin
         d = use_b ? ax * poly_b[i].x + ay * poly_b[i].y : ax * poly_a[i].x + ay * poly_a[i].y;
         if (i == 0 || d < lo) lo = d;
         if (i == 0 || d > hi) hi = d;
      end
   endfunction

   // any edge normal of one polygon that separates the pair
   function bit edges_separate(bit use_b);
      longint dx, dy, amin, amax, bmin, bmax;
      int     n, j;
      n = use_b ? n_b : n_a;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         dx = use_b ? poly_b[i].x - poly_b[j].x : poly_a[i].x - poly_a[j].x;
         dy = use_b ? poly_b[i].y - poly_b[j].y : poly_a[i].y - poly_a[j].y;
         span(0, -dy, dx, amin, amax);
         span(1, -dy, dx, bmin, bmax);
         if (amax < bmin || bmax < amin) return 1;
      end
      return 0;
   endfunction

   function logic [16:0] extent_overlap(longint ax, longint ay);
      longint amin, amax, bmin, bmax, o;
      span(0, ax, ay, amin, amax);
      span(1, ax, ay, bmin, bmax);
      o = (amin <= bmin) ? amax - bmin : bmax - amin;
      if (o > sat_pkg::OVL_LIMIT) o = sat_pkg::OVL_LIMIT;
      if (o < -sat_pkg::OVL_LIMIT) o = -sat_pkg::OVL_LIMIT;
      return o[16:0];
   endfunction

   // note one accepted vertex transaction
   function void note_vertex(bit is_b, logic signed [15:0] x, logic signed [15:0] y, bit last);
      verdict_t v;
      if (!is_b) begin
         if (a_done) begin
            n_a = 0;
            a_done = 0;
         end
         if (n_a < 8) begin
            poly_a[n_a].x = x;
            poly_a[n_a].y = y;
            n_a++;
         end else overflow = 1;
         if (last) a_done = 1;
         return;
      end
      if (n_b < 8) begin
         poly_b[n_b].x = x;
         poly_b[n_b].y = y;
         n_b++;
      end else overflow = 1;
      if (!last) return;
      v.bad = overflow || n_a == 0 || n_b == 0;
      v.hit = 0;
      v.ovl_x = '0;
      v.ovl_y = '0;
      if (!v.bad) begin
         v.hit = !edges_separate(0) && !edges_separate(1);
         if (v.hit) begin
            v.ovl_x = extent_overlap(1, 0);
            v.ovl_y = extent_overlap(0, 1);
         end
      end
      pending = {pending, v};
      n_a = 0;
      n_b = 0;
      overflow = 0;
      a_done = 0;
   endfunction

   task report(string what, logic [16:0] got, logic [16:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   // compare one result transaction with the oldest expectation
   task check_result(logic [39:0] data);
      verdict_t w;
      if (pending.size() == 0) begin
         report("unexpected result", data[16:0], '0);
         return;
      end
      w = pending.pop_front();
      if (data[0] !== w.hit) report("collided", data[0], w.hit);
      if (data[17:1] !== w.ovl_x) report("overlap_x", data[17:1], w.ovl_x);
      if (data[34:18] !== w.ovl_y) report("overlap_y", data[34:18], w.ovl_y);
      if (data[35] !== w.bad) report("bad_input", data[35], w.bad);
   endtask
endclass

module tb;
   import sat_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // vertex_x, vertex_y
   logic        req_tuser;   // func
   logic        req_tlast;   // last_vertex
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // collided, overlap_x, overlap_y, bad_input, pad
   logic        rsp_tlast;

   sat_scoreboard board;
   bit            hold_off;
   int            idle_cycles;
   int            burst_left;

   localparam int WATCHDOG = 20000;

   sat_polygon_collision_top dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_vertex(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog expired");
         $display("tb: done, errors");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // send one vertex, with sender bursts and gaps
   task send_vertex(bit is_b, logic [15:0] x, logic [15:0] y, bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= is_b;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // random coordinate: mostly clustered, sometimes anywhere
   function logic [15:0] coord(int centre, int reach);
      if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
      return 16'(centre + $urandom_range(0, 2 * reach) - reach);
   endfunction

   // one polygon roughly convex around a centre
   task send_polygon(bit is_b, int n, int cx, int cy, int r);
      int ang;
      for (int i = 0; i < n; i++) begin
         ang = i * 360 / n;
         send_vertex(is_b,
            16'(cx + $rtoi(r * $cos(ang * 3.14159 / 180.0))),
            16'(cy + $rtoi(r * $sin(ang * 3.14159 / 180.0))),
            i == n - 1);
      end
   endtask

   initial begin
      int kind, cx, cy, r, n;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      hold_off = 0;
      burst_left = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: overlapping squares, separated triangles, touching edges
      send_polygon(0, 4, 0, 0, 100);
      send_polygon(1, 4, 50, 0, 100);
      send_polygon(0, 3, 0, 0, 10);
      send_polygon(1, 3, 1000, 1000, 10);
      send_vertex(0, 0, 0, 0);
      send_vertex(0, 10, 0, 0);
      send_vertex(0, 10, 10, 1);
      send_vertex(1, 10, 0, 0);
      send_vertex(1, 20, 0, 0);
      send_vertex(1, 20, 10, 1);
      // extremes of the coordinates, saturating overlap
      send_vertex(0, 16'h8000, 16'h8000, 0);
      send_vertex(0, 16'h7fff, 16'h8000, 0);
      send_vertex(0, 16'h7fff, 16'h7fff, 1);
      send_vertex(1, 16'h8000, 16'h7fff, 0);
      send_vertex(1, 16'h7fff, 16'h7fff, 1);
      // empty polygon A and empty-ish degenerate single points
      send_vertex(1, 5, 5, 1);
      send_vertex(0, 3, 3, 1);
      send_vertex(1, 3, 3, 1);
      // A restart after closing, then overflow of A
      send_polygon(0, 3, 0, 0, 50);
      send_polygon(0, 9, 0, 0, 50);
      send_polygon(1, 3, 0, 0, 50);

      // random part
      for (int k = 0; k < 70; k++) begin
         if (k == 40) hold_off = 1;
         kind = $urandom_range(0, 9);
         cx = $urandom_range(0, 4000) - 2000;
         cy = $urandom_range(0, 4000) - 2000;
         r = $urandom_range(1, 1500);
         if (kind < 7) begin
            send_polygon(0, $urandom_range(3, 8), cx, cy, r);
            send_polygon(1, $urandom_range(3, 8), cx + $urandom_range(0, 2 * r) - r,
                         cy + $urandom_range(0, 2 * r) - r, $urandom_range(1, 1500));
         end else if (kind == 7) begin
            send_polygon(1'($urandom_range(0, 1)), $urandom_range(8, 10), cx, cy, r);
            send_polygon(1, $urandom_range(1, 9), cx, cy, r);
         end else begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               send_vertex(1'($urandom_range(0, 1)), coord(cx, r), coord(cy, r),
                           $urandom_range(0, 3) == 0);
            send_vertex(1, coord(cx, r), coord(cy, r), 1);
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
